FILE: hw/rtl/grid_astar_door_key_path_core_assert.svh
// Assertion macros for the grid path finder.
`ifndef GRID_ASTAR_DOOR_KEY_PATH_CORE_ASSERT_SVH
`define GRID_ASTAR_DOOR_KEY_PATH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GAD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define GAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define GAD_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: hw/rtl/gadkp_pkg.sv
`timescale 1ns / 1ps
package gadkp_pkg;
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_W = 5;
  localparam int COL_W = 5;
  localparam int IDX_W = ROW_W + COL_W;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int LEN_W = 11;
  localparam int DIM_W = 6;
  localparam int F_W = 12;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [2:0] CELL_FLOOR = 3'd0;
  localparam logic [2:0] CELL_DOOR_CLOSED = 3'd2;
  localparam logic [2:0] CELL_DOOR_OPEN = 3'd3;
  localparam logic [2:0] CELL_TANK_A = 3'd4;
  localparam logic [2:0] CELL_TANK_B = 3'd5;
  localparam logic [2:0] CELL_FINISH = 3'd6;

  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_A = 2'd1;
  localparam logic [1:0] KEY_B = 2'd2;

  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd20;

  typedef struct packed {
    logic              open;
    logic              closed;
    logic [1:0]        key;
    logic [LEN_W-1:0]  cost;
    logic [1:0]        par;
  } node_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic clr_step;
    logic seed;
    logic scan_init;
    logic scan_step;
    logic close_best;
    logic exp_rd;
    logic exp_wr;
    logic bt_init;
    logic bt_rd;
    logic bt_wr;
    logic set_len;
    logic rd_issue;
    logic emit_search;
    logic emit_read;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic start_in;
    logic scan_done;
    logic any;
    logic best_goal;
    logic dir_last;
    logic bt_last;
    logic out_busy;
  } sts_t;

  function automatic logic passable(logic [2:0] code, logic [1:0] key);
    logic ok;
    case (code)
      CELL_FLOOR, CELL_DOOR_OPEN, CELL_TANK_A, CELL_TANK_B, CELL_FINISH: ok = 1'b1;
      CELL_DOOR_CLOSED: ok = (key == KEY_A);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [ROW_W-1:0] absdiff(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > mx) r = mx;
    else r = v;
    return r;
  endfunction
endpackage

FILE: hw/rtl/gadkp_ctrl.sv
`timescale 1ns / 1ps
module gadkp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  gadkp_pkg::sts_t sts_i,
  output gadkp_pkg::cmd_t cmd_o
);
  import gadkp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR = 4'd1;
  localparam logic [3:0] S_SEED = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_EXP_RD = 4'd4;
  localparam logic [3:0] S_EXP_WR = 4'd5;
  localparam logic [3:0] S_BT_RD = 4'd6;
  localparam logic [3:0] S_BT_WR = 4'd7;
  localparam logic [3:0] S_RD = 4'd8;
  localparam logic [3:0] S_EMIT_S = 4'd9;
  localparam logic [3:0] S_EMIT_R = 4'd10;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_LOAD: cmd_o.load = 1'b1;
            REQ_SEARCH: begin
              cmd_o.capture = 1'b1;
              state_d = S_CLR;
            end
            REQ_READ: begin
              cmd_o.capture = 1'b1;
              state_d = S_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = sts_i.start_in ? S_SEED : S_EMIT_S;
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          if (!sts_i.any) begin
            state_d = S_EMIT_S;
          end else begin
            cmd_o.close_best = 1'b1;
            if (sts_i.best_goal) begin
              cmd_o.bt_init = 1'b1;
              state_d = S_BT_RD;
            end else begin
              state_d = S_EXP_RD;
            end
          end
        end
      end
      S_EXP_RD: begin
        cmd_o.exp_rd = 1'b1;
        state_d = S_EXP_WR;
      end
      S_EXP_WR: begin
        cmd_o.exp_wr = 1'b1;
        if (sts_i.dir_last) begin
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_EXP_RD;
        end
      end
      S_BT_RD: begin
        cmd_o.bt_rd = 1'b1;
        state_d = S_BT_WR;
      end
      S_BT_WR: begin
        if (sts_i.bt_last) begin
          cmd_o.set_len = 1'b1;
          state_d = S_EMIT_S;
        end else begin
          cmd_o.bt_wr = 1'b1;
          state_d = S_BT_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_EMIT_R;
      end
      S_EMIT_S: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_search = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT_R: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_read = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: hw/rtl/gadkp_dp.sv
`timescale 1ns / 1ps
module gadkp_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gadkp_pkg::DIM_W-1:0] cfg_wdata_i,
  input  logic [gadkp_pkg::ROW_W-1:0] row_i,
  input  logic [gadkp_pkg::COL_W-1:0] col_i,
  input  logic [2:0]                  cell_code_i,
  input  logic [gadkp_pkg::ROW_W-1:0] goal_row_i,
  input  logic [gadkp_pkg::COL_W-1:0] goal_col_i,
  input  logic [gadkp_pkg::IDX_W-1:0] step_index_i,
  input  gadkp_pkg::cmd_t             cmd_i,
  output gadkp_pkg::sts_t             sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic                        found_o,
  output logic [gadkp_pkg::LEN_W-1:0] path_length_o,
  output logic [gadkp_pkg::ROW_W-1:0] step_row_o,
  output logic [gadkp_pkg::COL_W-1:0] step_col_o,
  output logic                        step_valid_o
);
  import gadkp_pkg::*;

  logic [2:0]       cell_mem [CELLS];
  node_t            node_mem [CELLS];
  logic [IDX_W-1:0] path_mem [CELLS];

  logic [DIM_W-1:0] rows_q, cols_q, er, ec;
  logic [ROW_W-1:0] sr_q, gr_q, scan_r_q, p_r_q, best_r_q, nr_q, cur_r_q;
  logic [COL_W-1:0] sc_q, gc_q, scan_c_q, p_c_q, best_c_q, nc_q, cur_c_q;
  logic [IDX_W-1:0] sidx_q, clr_q, node_ra, path_rd_q;
  logic             issued_q, p_v_q, any_q, nin_q;
  logic [F_W-1:0]   bestf_q, f;
  node_t            best_q, node_rd_q, node_wd;
  logic [2:0]       cell_rd_q;
  logic [1:0]       dir_q;
  logic [LEN_W-1:0] k_q, len_q, t;
  logic             node_re, node_we;
  logic [IDX_W-1:0] node_wa;
  logic             scan_issue, scan_last, cand;
  logic [DIM_W-1:0] nr6, nc6;
  logic             nin;
  logic             upd;
  logic [ROW_W-1:0] mv_r;
  logic [COL_W-1:0] mv_c;
  logic             out_valid_q, kind_q, found_q, sval_q;
  logic [LEN_W-1:0] olen_q;
  logic [ROW_W-1:0] orow_q;
  logic [COL_W-1:0] ocol_q;
  logic             rd_valid;

  assign er = clamp_dim(rows_q, DIM_W'(MAX_ROWS));
  assign ec = clamp_dim(cols_q, DIM_W'(MAX_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_RESET;
      cols_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ROWS) rows_q <= cfg_wdata_i;
      else cols_q <= cfg_wdata_i;
    end
  end

  assign scan_issue = cmd_i.scan_step && !issued_q;
  assign scan_last = ({1'b0, scan_r_q} == er - DIM_W'(1)) &&
                     ({1'b0, scan_c_q} == ec - DIM_W'(1));
  assign f = F_W'(node_rd_q.cost) + F_W'(absdiff(p_r_q, gr_q)) + F_W'(absdiff(p_c_q, gc_q));
  assign cand = p_v_q && node_rd_q.open && !node_rd_q.closed && (!any_q || f < bestf_q);

  always_comb begin
    nr6 = {1'b0, best_r_q};
    nc6 = {1'b0, best_c_q};
    nin = 1'b0;
    case (dir_q)
      DIR_UP: begin
        nr6 = {1'b0, best_r_q} - DIM_W'(1);
        nin = (best_r_q != '0);
      end
      DIR_DOWN: begin
        nr6 = {1'b0, best_r_q} + DIM_W'(1);
        nin = (nr6 < er);
      end
      DIR_LEFT: begin
        nc6 = {1'b0, best_c_q} - DIM_W'(1);
        nin = (best_c_q != '0);
      end
      DIR_RIGHT: begin
        nc6 = {1'b0, best_c_q} + DIM_W'(1);
        nin = (nc6 < ec);
      end
      default: nin = 1'b0;
    endcase
  end

  assign t = best_q.cost + LEN_W'(1);
  assign upd = nin_q && !node_rd_q.closed && passable(cell_rd_q, best_q.key) &&
               (!node_rd_q.open || t < node_rd_q.cost);

  always_comb begin
    mv_r = cur_r_q;
    mv_c = cur_c_q;
    case (node_rd_q.par)
      DIR_UP: mv_r = cur_r_q - ROW_W'(1);
      DIR_DOWN: mv_r = cur_r_q + ROW_W'(1);
      DIR_LEFT: mv_c = cur_c_q - COL_W'(1);
      DIR_RIGHT: mv_c = cur_c_q + COL_W'(1);
      default: mv_r = cur_r_q;
    endcase
  end

  always_comb begin
    node_re = 1'b0;
    node_ra = {scan_r_q, scan_c_q};
    if (scan_issue) begin
      node_re = 1'b1;
    end else if (cmd_i.exp_rd) begin
      node_re = 1'b1;
      node_ra = {nr6[ROW_W-1:0], nc6[COL_W-1:0]};
    end else if (cmd_i.bt_rd) begin
      node_re = 1'b1;
      node_ra = {cur_r_q, cur_c_q};
    end
  end

  always_comb begin
    node_we = 1'b0;
    node_wa = clr_q;
    node_wd = '0;
    if (cmd_i.clr_step) begin
      node_we = 1'b1;
    end else if (cmd_i.seed) begin
      node_we = 1'b1;
      node_wa = {sr_q, sc_q};
      node_wd.open = 1'b1;
    end else if (cmd_i.close_best) begin
      node_we = 1'b1;
      node_wa = {best_r_q, best_c_q};
      node_wd = best_q;
      node_wd.open = 1'b0;
      node_wd.closed = 1'b1;
    end else if (cmd_i.exp_wr && upd) begin
      node_we = 1'b1;
      node_wa = {nr_q, nc_q};
      node_wd.open = 1'b1;
      node_wd.closed = 1'b0;
      node_wd.cost = t;
      node_wd.par = dir_q ^ 2'd1;
      if (cell_rd_q == CELL_TANK_A) node_wd.key = KEY_A;
      else if (cell_rd_q == CELL_TANK_B) node_wd.key = KEY_B;
      else node_wd.key = best_q.key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) cell_mem[{row_i, col_i}] <= cell_code_i;
    if (cmd_i.exp_rd) cell_rd_q <= cell_mem[node_ra];
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_rd_q <= node_mem[node_ra];
    if (cmd_i.bt_rd) path_mem[k_q[IDX_W-1:0] - IDX_W'(1)] <= {cur_r_q, cur_c_q};
    if (cmd_i.rd_issue) path_rd_q <= path_mem[sidx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      clr_q <= '0;
      issued_q <= 1'b0;
      p_v_q <= 1'b0;
      any_q <= 1'b0;
      dir_q <= '0;
      sr_q <= '0;
      sc_q <= '0;
      gr_q <= '0;
      gc_q <= '0;
      sidx_q <= '0;
      scan_r_q <= '0;
      scan_c_q <= '0;
      p_r_q <= '0;
      p_c_q <= '0;
      bestf_q <= '0;
      best_r_q <= '0;
      best_c_q <= '0;
      best_q <= '0;
      nr_q <= '0;
      nc_q <= '0;
      nin_q <= 1'b0;
      k_q <= '0;
      cur_r_q <= '0;
      cur_c_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        sr_q <= row_i;
        sc_q <= col_i;
        gr_q <= goal_row_i;
        gc_q <= goal_col_i;
        sidx_q <= step_index_i;
        clr_q <= '0;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + IDX_W'(1);
        len_q <= '0;
      end
      if (cmd_i.scan_init) begin
        scan_r_q <= '0;
        scan_c_q <= '0;
        issued_q <= 1'b0;
        any_q <= 1'b0;
        p_v_q <= 1'b0;
      end else begin
        p_v_q <= scan_issue;
        if (scan_issue) begin
          p_r_q <= scan_r_q;
          p_c_q <= scan_c_q;
          if (scan_last) begin
            issued_q <= 1'b1;
          end else if ({1'b0, scan_c_q} == ec - DIM_W'(1)) begin
            scan_c_q <= '0;
            scan_r_q <= scan_r_q + ROW_W'(1);
          end else begin
            scan_c_q <= scan_c_q + COL_W'(1);
          end
        end
        if (cand) begin
          any_q <= 1'b1;
          bestf_q <= f;
          best_r_q <= p_r_q;
          best_c_q <= p_c_q;
          best_q <= node_rd_q;
        end
      end
      if (cmd_i.close_best) dir_q <= '0;
      if (cmd_i.exp_rd) begin
        nr_q <= nr6[ROW_W-1:0];
        nc_q <= nc6[COL_W-1:0];
        nin_q <= nin;
      end
      if (cmd_i.exp_wr) dir_q <= dir_q + 2'd1;
      if (cmd_i.bt_init) begin
        k_q <= best_q.cost + LEN_W'(1);
        cur_r_q <= best_r_q;
        cur_c_q <= best_c_q;
      end
      if (cmd_i.bt_wr) begin
        k_q <= k_q - LEN_W'(1);
        cur_r_q <= mv_r;
        cur_c_q <= mv_c;
      end
      if (cmd_i.set_len) len_q <= best_q.cost + LEN_W'(1);
    end
  end

  assign rd_valid = {1'b0, sidx_q} < len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_search || cmd_i.emit_read) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_search || cmd_i.emit_read) begin
      kind_q <= cmd_i.emit_read;
      found_q <= (len_q != '0);
      olen_q <= len_q;
      sval_q <= cmd_i.emit_read && rd_valid;
      orow_q <= (cmd_i.emit_read && rd_valid) ? path_rd_q[IDX_W-1:COL_W] : '0;
      ocol_q <= (cmd_i.emit_read && rd_valid) ? path_rd_q[COL_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_kind_o = kind_q;
  assign found_o = found_q;
  assign path_length_o = olen_q;
  assign step_row_o = orow_q;
  assign step_col_o = ocol_q;
  assign step_valid_o = sval_q;

  assign sts_o.clr_done = (clr_q == {IDX_W{1'b1}});
  assign sts_o.start_in = ({1'b0, sr_q} < er) && ({1'b0, sc_q} < ec);
  assign sts_o.scan_done = issued_q && !p_v_q;
  assign sts_o.any = any_q;
  assign sts_o.best_goal = (best_r_q == gr_q) && (best_c_q == gc_q);
  assign sts_o.dir_last = (dir_q == DIR_RIGHT);
  assign sts_o.bt_last = (k_q == LEN_W'(1));
  assign sts_o.out_busy = out_valid_q;
endmodule

FILE: hw/rtl/grid_astar_door_key_path_core.sv
// A load or unknown transaction leaves the block idle; a read result passes a path-memory
// read and an emit state that waits while an earlier result is held. A search clears the
// node memory and, for a start inside the grid, repeats a full grid scan and a four-neighbour
// expansion per closed cell until none is open or the goal is closed and backtracked.
// Reset is asynchronous and active low: the row and column counts return to 20 and
// the stored path length to zero; the map memory holds whatever was last loaded.
`timescale 1ns / 1ps
`include "grid_astar_door_key_path_core_assert.svh"
module grid_astar_door_key_path_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gadkp_pkg::DIM_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [gadkp_pkg::ROW_W-1:0] row_i,
  input  logic [gadkp_pkg::COL_W-1:0] col_i,
  input  logic [2:0]                  cell_code_i,
  input  logic [gadkp_pkg::ROW_W-1:0] goal_row_i,
  input  logic [gadkp_pkg::COL_W-1:0] goal_col_i,
  input  logic [gadkp_pkg::IDX_W-1:0] step_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic                        found_o,
  output logic [gadkp_pkg::LEN_W-1:0] path_length_o,
  output logic [gadkp_pkg::ROW_W-1:0] step_row_o,
  output logic [gadkp_pkg::COL_W-1:0] step_col_o,
  output logic                        step_valid_o
);
  import gadkp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gadkp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gadkp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .cell_code_i   (cell_code_i),
    .goal_row_i    (goal_row_i),
    .goal_col_i    (goal_col_i),
    .step_index_i  (step_index_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .found_o       (found_o),
    .path_length_o (path_length_o),
    .step_row_o    (step_row_o),
    .step_col_o    (step_col_o),
    .step_valid_o  (step_valid_o)
  );

  `GAD_ASSERT_IMP(a_found_len, clk_i, rst_ni, out_valid_o, found_o == (path_length_o != '0), "found disagrees with length")
  `GAD_ASSERT_IMP(a_search_nostep, clk_i, rst_ni, out_valid_o && !result_kind_o, !step_valid_o, "search answer with a step")
  `GAD_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, cmd.clr_step || cmd.scan_step, in_stall_o, "input taken during search")
endmodule

FILE: tb/sv/tb_grid_astar_door_key_path_core.sv
`timescale 1ns / 1ps
module tb_grid_astar_door_key_path_core;
  import gadkp_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [2:0] CELL_WALL = 3'd1;
  localparam logic [2:0] CELL_BLOCKED = 3'd7;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic             kind;
    logic             found;
    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] srow;
    logic [COL_W-1:0] scol;
    logic             sval;
  } answer_t;

  typedef struct {
    logic [1:0]       req;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [2:0]       code;
    logic [ROW_W-1:0] grow;
    logic [COL_W-1:0] gcol;
    logic [IDX_W-1:0] sidx;
    bit               typed;
    answer_t          ans;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [DIM_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [ROW_W-1:0] row_i = '0;
  logic [COL_W-1:0] col_i = '0;
  logic [2:0] cell_code_i = '0;
  logic [ROW_W-1:0] goal_row_i = '0;
  logic [COL_W-1:0] goal_col_i = '0;
  logic [IDX_W-1:0] step_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic result_kind_o;
  logic found_o;
  logic [LEN_W-1:0] path_length_o;
  logic [ROW_W-1:0] step_row_o;
  logic [COL_W-1:0] step_col_o;
  logic step_valid_o;

  grid_astar_door_key_path_core u_top (.*);

  // Predictor state.
  logic [2:0] grid_map [CELLS];
  bit closed_q [CELLS];
  bit open_q [CELLS];
  int cost_q [CELLS];
  int par_q [CELLS];
  logic [1:0] key_q [CELLS];
  int path_cells [CELLS];
  int path_len;
  logic [DIM_W-1:0] rows_cfg = DIM_RESET;
  logic [DIM_W-1:0] cols_cfg = DIM_RESET;

  answer_t answers_due [$];
  probe_t table_q [$];
  int errors = 0;
  int results_seen = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit held_once = 1'b0;
  int drow [4] = '{-1, 1, 0, 0};
  int dcol [4] = '{0, 0, -1, 1};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_grid_astar_door_key_path_core: errors");
      $finish;
    end
  end

  function automatic void add_row(probe_t p);
    table_q = {table_q, p};
  endfunction

  function automatic void queue_answer(answer_t a);
    answers_due = {answers_due, a};
  endfunction

  function automatic int eff_dim(logic [DIM_W-1:0] v, int mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : int'(v);
  endfunction

  function automatic bit can_enter(logic [2:0] code, logic [1:0] key);
    case (code)
      CELL_FLOOR, CELL_DOOR_OPEN, CELL_TANK_A, CELL_TANK_B, CELL_FINISH: return 1'b1;
      CELL_DOOR_CLOSED: return key == KEY_A;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void find_path(int sr, int sc, int gr, int gc);
    int er, ec, best, bestf, br, bc, f, nr, nc, n, t, goal, idx, r, c, d;
    bit any, hit;
    er = eff_dim(rows_cfg, MAX_ROWS);
    ec = eff_dim(cols_cfg, MAX_COLS);
    hit = 1'b0;
    goal = 0;
    for (int i = 0; i < CELLS; i++) begin
      closed_q[i] = 0;
      open_q[i] = 0;
      cost_q[i] = 0;
      key_q[i] = KEY_NONE;
    end
    path_len = 0;
    if (sr >= er || sc >= ec) return;
    open_q[sr * MAX_COLS + sc] = 1;
    forever begin
      any = 0;
      best = 0;
      bestf = 0;
      br = 0;
      bc = 0;
      for (int rr = 0; rr < er; rr++) begin
        for (int cc = 0; cc < ec; cc++) begin
          idx = rr * MAX_COLS + cc;
          if (open_q[idx] && !closed_q[idx]) begin
            f = cost_q[idx] + ((rr > gr) ? rr - gr : gr - rr) + ((cc > gc) ? cc - gc : gc - cc);
            if (!any || f < bestf) begin
              any = 1;
              bestf = f;
              best = idx;
              br = rr;
              bc = cc;
            end
          end
        end
      end
      if (!any) break;
      closed_q[best] = 1;
      open_q[best] = 0;
      if (br == gr && bc == gc) begin
        hit = 1;
        goal = best;
        break;
      end
      for (int k = 0; k < 4; k++) begin
        nr = br + drow[k];
        nc = bc + dcol[k];
        if (nr < 0 || nc < 0 || nr >= er || nc >= ec) continue;
        n = nr * MAX_COLS + nc;
        if (closed_q[n]) continue;
        if (!can_enter(grid_map[n], key_q[best])) continue;
        t = cost_q[best] + 1;
        if (!open_q[n] || t < cost_q[n]) begin
          par_q[n] = k ^ 1;
          cost_q[n] = t;
          if (grid_map[n] == CELL_TANK_A) key_q[n] = KEY_A;
          else if (grid_map[n] == CELL_TANK_B) key_q[n] = KEY_B;
          else key_q[n] = key_q[best];
          open_q[n] = 1;
        end
      end
    end
    if (!hit) return;
    idx = goal;
    for (int k = cost_q[goal] + 1; k > 0; k--) begin
      path_cells[k - 1] = idx;
      if (k == 1) break;
      d = par_q[idx];
      r = (idx / MAX_COLS + drow[d] + MAX_ROWS) % MAX_ROWS;
      c = (idx % MAX_COLS + dcol[d] + MAX_COLS) % MAX_COLS;
      idx = r * MAX_COLS + c;
    end
    path_len = cost_q[goal] + 1;
  endfunction

  // Updates the predictor for one accepted transaction; returns 1 if it yields an answer.
  function automatic bit predict(probe_t p, output answer_t a);
    int hit_idx;
    a = '0;
    case (p.req)
      REQ_LOAD: begin
        grid_map[p.row * MAX_COLS + p.col] = p.code;
        return 0;
      end
      REQ_SEARCH: begin
        find_path(p.row, p.col, p.grow, p.gcol);
        a.found = path_len != 0;
        a.len = LEN_W'(path_len);
        return 1;
      end
      REQ_READ: begin
        a.kind = 1'b1;
        a.found = path_len != 0;
        a.len = LEN_W'(path_len);
        if (p.sidx < path_len) begin
          hit_idx = path_cells[p.sidx];
          a.sval = 1'b1;
          a.srow = ROW_W'(hit_idx / MAX_COLS);
          a.scol = COL_W'(hit_idx % MAX_COLS);
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send(probe_t p);
    int gap;
    answer_t a;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i = p.req;
    row_i = p.row;
    col_i = p.col;
    cell_code_i = p.code;
    goal_row_i = p.grow;
    goal_col_i = p.gcol;
    step_index_i = p.sidx;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (predict(p, a)) begin
      if (p.typed) begin
        if (a !== p.ans) begin
          $display("%0t: table answer differs, expected %p actual %p", $realtime, p.ans, a);
          errors++;
        end
        queue_answer(p.ans);
      end else begin
        queue_answer(a);
      end
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ROWS) rows_cfg = val;
    else cols_cfg = val;
  endtask

  function automatic probe_t rand_probe();
    probe_t p;
    int er, ec, pick;
    er = eff_dim(rows_cfg, MAX_ROWS);
    ec = eff_dim(cols_cfg, MAX_COLS);
    p.row = ROW_W'($urandom);
    p.col = COL_W'($urandom);
    p.code = ($urandom_range(0, 2) == 0) ? CELL_FLOOR : 3'($urandom);
    p.grow = ROW_W'($urandom);
    p.gcol = COL_W'($urandom);
    p.sidx = IDX_W'($urandom);
    p.typed = 0;
    p.ans = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      p.req = REQ_LOAD;
      if ($urandom_range(0, 9) != 0) begin
        p.row = ROW_W'($urandom_range(0, er - 1));
        p.col = COL_W'($urandom_range(0, ec - 1));
      end
    end else if (pick < 55) begin
      p.req = REQ_SEARCH;
      if ($urandom_range(0, 9) != 0) begin
        p.row = ROW_W'($urandom_range(0, er - 1));
        p.col = COL_W'($urandom_range(0, ec - 1));
        p.grow = ROW_W'($urandom_range(0, er - 1));
        p.gcol = COL_W'($urandom_range(0, ec - 1));
      end
    end else if (pick < 96) begin
      p.req = REQ_READ;
      if ($urandom_range(0, 7) != 0) p.sidx = IDX_W'($urandom_range(0, path_len + 1));
    end else begin
      p.req = REQ_NONE;
    end
    return p;
  endfunction

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_once && results_seen >= 30) begin
        held_once = 1'b1;
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d", $realtime,
                 result_kind_o);
        errors++;
      end else begin
        e = answers_due.pop_front();
        if (result_kind_o !== e.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $realtime, e.kind, result_kind_o);
          errors++;
        end
        if (found_o !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $realtime, e.found, found_o);
          errors++;
        end
        if (path_length_o !== e.len) begin
          $display("%0t: path_length expected %0d actual %0d", $realtime, e.len, path_length_o);
          errors++;
        end
        if (step_row_o !== e.srow) begin
          $display("%0t: step_row expected %0d actual %0d", $realtime, e.srow, step_row_o);
          errors++;
        end
        if (step_col_o !== e.scol) begin
          $display("%0t: step_col expected %0d actual %0d", $realtime, e.scol, step_col_o);
          errors++;
        end
        if (step_valid_o !== e.sval) begin
          $display("%0t: step_valid expected %0d actual %0d", $realtime, e.sval, step_valid_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int dims [$];
    for (int i = 0; i < CELLS; i++) grid_map[i] = CELL_FLOOR;
    path_len = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row('{REQ_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0}});
    add_row('{REQ_NONE, 31, 31, 7, 31, 31, 1023, 0, '0});
    add_row('{REQ_SEARCH, 0, 0, 0, 0, 0, 0, 1, '{0, 1, 1, 0, 0, 0}});
    add_row('{REQ_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 1, 1, 0, 0, 1}});
    // Every cell that a later search can reach is written first.
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        if (r < 2 || c < 2 || (r < 8 && c < 8))
          add_row('{REQ_LOAD, ROW_W'(r), COL_W'(c), CELL_FLOOR, ROW_W'($urandom),
                    COL_W'($urandom), IDX_W'($urandom), 0, '0});
    foreach (table_q[i]) send(table_q[i]);
    table_q.delete();

    wait_idle();
    write_reg(CFG_ROWS, 6'd4);
    write_reg(CFG_COLS, 6'd6);
    add_row('{REQ_LOAD, 0, 1, CELL_TANK_A, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 1, 0, CELL_WALL, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 1, 1, CELL_WALL, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 0, 2, CELL_DOOR_CLOSED, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 1, 2, CELL_WALL, 0, 0, 0, 0, '0});
    add_row('{REQ_SEARCH, 0, 0, 0, 0, 3, 0, 0, '0});
    add_row('{REQ_READ, 0, 0, 0, 0, 0, 3, 0, '0});
    add_row('{REQ_READ, 0, 0, 0, 0, 0, 4, 0, '0});
    add_row('{REQ_READ, 0, 0, 0, 0, 0, 1023, 0, '0});
    add_row('{REQ_LOAD, 2, 2, CELL_TANK_B, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 2, 3, CELL_DOOR_CLOSED, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 3, 3, CELL_BLOCKED, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 3, 4, CELL_FINISH, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 2, 4, CELL_DOOR_OPEN, 0, 0, 0, 0, '0});
    add_row('{REQ_SEARCH, 2, 0, 0, 3, 5, 0, 0, '0});
    add_row('{REQ_READ, 0, 0, 0, 0, 0, 2, 0, '0});
    add_row('{REQ_SEARCH, 1, 1, 0, 1, 1, 0, 1, '{0, 1, 1, 0, 0, 0}});
    add_row('{REQ_SEARCH, 31, 31, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}});
    add_row('{REQ_READ, 0, 0, 0, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0}});
    add_row('{REQ_SEARCH, 0, 0, 0, 31, 31, 0, 1, '{0, 0, 0, 0, 0, 0}});
    add_row('{REQ_LOAD, 31, 31, CELL_BLOCKED, 0, 0, 0, 0, '0});
    add_row('{REQ_LOAD, 31, 31, CELL_FLOOR, 0, 0, 0, 0, '0});
    foreach (table_q[i]) send(table_q[i]);

    dims = '{0, 63, 32, 33, 2, 3, 5, 8};
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      no_idle = (ph % 4 == 3);
      if (ph < 4) begin
        write_reg(CFG_ROWS, DIM_W'(dims[2 * ph]));
        write_reg(CFG_COLS, (dims[2 * ph] > 8) ? DIM_W'($urandom_range(1, 2)) :
                                                  DIM_W'($urandom_range(1, 8)));
      end else if (ph < 6) begin
        write_reg(CFG_COLS, DIM_W'(dims[ph - 3]));
        write_reg(CFG_ROWS, DIM_W'($urandom_range(1, 2)));
      end else begin
        write_reg(CFG_ROWS, DIM_W'($urandom_range(1, 7)));
        write_reg(CFG_COLS, DIM_W'($urandom_range(1, 7)));
      end
      repeat (47) send(rand_probe());
    end

    in_valid_i = 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_grid_astar_door_key_path_core: clean");
    end else begin
      $display("tb_grid_astar_door_key_path_core: errors");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/gadkp_pkg.sv
hw/rtl/gadkp_ctrl.sv
hw/rtl/gadkp_dp.sv
hw/rtl/grid_astar_door_key_path_core.sv
tb/sv/tb_grid_astar_door_key_path_core.sv
